// ----- hdl/bpw_pkg.sv -----
// ----------------------------------------------------------------------------
// bpw_pkg
// Shared types, defaults and Q1.15 arithmetic for the polynomial warp core.
// ----------------------------------------------------------------------------
package bpw_pkg;

	localparam int DEF_MAX_ORDER   = 3;
	localparam int DEF_TABLE_DEPTH = 32;

	localparam int ORDER_W = 2;
	localparam int INDEX_W = 5;
	localparam int COEFF_W = 32;
	localparam int COORD_W = 16;
	localparam int PROD_W  = COEFF_W + COORD_W;

	localparam logic signed [COORD_W-1:0] Q15_ONE = 16'sh7fff;

	typedef enum logic {
		KIND_LOAD  = 1'b0,
		KIND_POINT = 1'b1
	} kind_t;

	// load fields carried alongside the power vectors
	typedef struct packed {
		kind_t               kind;
		logic [INDEX_W-1:0]  coeff_index;
		logic [COEFF_W-1:0]  coeff_value;
	} item_t;

	// floor(a*b / 2^15), +1 saturated to 32767
	function automatic logic signed [COORD_W-1:0] q15_mul(
		input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b
	);
		logic signed [2*COORD_W-1:0] p;
		logic signed [COORD_W:0]     r;
		p = a * b;
		r = $signed(p[2*COORD_W-1:COORD_W-1]);
		if (r > 17'sd32767)
			return Q15_ONE;
		return r[COORD_W-1:0];
	endfunction

endpackage

// ----- hdl/bivariate_poly_warp_eval_core.sv -----
// ----------------------------------------------------------------------------
// bivariate_poly_warp_eval_core
// Tensor-product bivariate polynomial warp of Q1.15 points to Q16.16.
// ----------------------------------------------------------------------------
// Takes one item per cycle, loads and points alike, and returns one result
// per point through the input register, MAX_ORDER-1 power steps, monomial,
// product, row-sum and output register. The Q1.15 and 32x16 multipliers
// each sit in a register stage; every stage advances together whenever
// the output register is empty or being taken. Load items write the
// coefficient table at the product stage, so they take effect in stream
// order and give no result. The user must write poly_order only while the
// pipeline is empty; the block itself does not enforce it.
module bivariate_poly_warp_eval_core #(
	parameter int MAX_ORDER   = bpw_pkg::DEF_MAX_ORDER,
	parameter int TABLE_DEPTH = bpw_pkg::DEF_TABLE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bpw_pkg::ORDER_W-1:0]   cfg_data,   // poly_order
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [71:0]                   s_tdata,    // coeff_index, coeff_value, x_in, y_in
	input  logic                          s_tuser,    // kind
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [71:0]                   m_tdata     // x_out, y_out, clipped
);
	import bpw_pkg::*;

	localparam int N1    = MAX_ORDER + 1;
	localparam int NT    = N1 * N1;
	localparam int ORD_W = $clog2(N1);

	logic [ORDER_W-1:0] order_q;
	logic [ORD_W-1:0]   n;
	logic               adv;

	logic                 v_s1;
	item_t                item_s1;
	logic [COORD_W-1:0]   x_s1, y_s1;

	logic [MAX_ORDER-1:0]                          pv;
	item_t [MAX_ORDER-1:0]                         pitem;
	logic [MAX_ORDER-1:0][MAX_ORDER:0][COORD_W-1:0] ppx, ppy;

	logic                      tv;
	logic [NT-1:0][PROD_W-1:0] prodx, prody;
	logic [COEFF_W-1:0]        x_out, y_out;
	logic                      clipped;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORDER_W'(2);
		end else if (cfg_valid) begin
			order_q <= cfg_data;
		end
	end

	always_comb begin
		if (int'(order_q) > MAX_ORDER)
			n = ORD_W'(MAX_ORDER);
		else
			n = ORD_W'(order_q);
	end

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1.kind        <= kind_t'(s_tuser);
			item_s1.coeff_index <= s_tdata[4:0];
			item_s1.coeff_value <= s_tdata[36:5];
			x_s1                <= s_tdata[52:37];
			y_s1                <= s_tdata[68:53];
		end
	end

	assign pv[0]     = v_s1;
	assign pitem[0]  = item_s1;
	assign ppx[0][0] = Q15_ONE;
	assign ppy[0][0] = Q15_ONE;
	assign ppx[0][1] = x_s1;
	assign ppy[0][1] = y_s1;

	for (genvar k = 2; k <= MAX_ORDER; k++) begin : g_pz
		assign ppx[0][k] = '0;
		assign ppy[0][k] = '0;
	end

	for (genvar g = 0; g < MAX_ORDER - 1; g++) begin : g_pow
		bpw_power #(
			.MAX_ORDER (MAX_ORDER),
			.K         (g + 2)
		) u_pow (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.in_v     (pv[g]),
			.in_item  (pitem[g]),
			.in_px    (ppx[g]),
			.in_py    (ppy[g]),
			.out_v    (pv[g+1]),
			.out_item (pitem[g+1]),
			.out_px   (ppx[g+1]),
			.out_py   (ppy[g+1])
		);
	end

	bpw_term #(
		.MAX_ORDER   (MAX_ORDER),
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_term (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.n       (n),
		.in_v    (pv[MAX_ORDER-1]),
		.in_item (pitem[MAX_ORDER-1]),
		.in_px   (ppx[MAX_ORDER-1]),
		.in_py   (ppy[MAX_ORDER-1]),
		.out_v   (tv),
		.prodx   (prodx),
		.prody   (prody)
	);

	bpw_acc #(
		.MAX_ORDER (MAX_ORDER)
	) u_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_v    (tv),
		.prodx   (prodx),
		.prody   (prody),
		.out_v   (m_tvalid),
		.x_out   (x_out),
		.y_out   (y_out),
		.clipped (clipped)
	);

	assign m_tdata = {7'd0, clipped, y_out, x_out};

endmodule

// ----- hdl/bpw_power.sv -----
// ----------------------------------------------------------------------------
// bpw_power
// One power step: fills in x^K and y^K from x^(K-1), y^(K-1).
// ----------------------------------------------------------------------------
module bpw_power #(
	parameter int MAX_ORDER = bpw_pkg::DEF_MAX_ORDER,
	parameter int K         = 2
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        adv,
	input  logic                                        in_v,
	input  bpw_pkg::item_t                              in_item,
	input  logic [MAX_ORDER:0][bpw_pkg::COORD_W-1:0]    in_px,
	input  logic [MAX_ORDER:0][bpw_pkg::COORD_W-1:0]    in_py,
	output logic                                        out_v,
	output bpw_pkg::item_t                              out_item,
	output logic [MAX_ORDER:0][bpw_pkg::COORD_W-1:0]    out_px,
	output logic [MAX_ORDER:0][bpw_pkg::COORD_W-1:0]    out_py
);
	import bpw_pkg::*;

	logic                            v_sp;
	item_t                           item_sp;
	logic [MAX_ORDER:0][COORD_W-1:0] px_sp, py_sp;
	logic [MAX_ORDER:0][COORD_W-1:0] px_nxt, py_nxt;

	always_comb begin
		px_nxt    = in_px;
		py_nxt    = in_py;
		px_nxt[K] = q15_mul($signed(in_px[K-1]), $signed(in_px[1]));
		py_nxt[K] = q15_mul($signed(in_py[K-1]), $signed(in_py[1]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sp <= 1'b0;
		end else if (adv) begin
			v_sp <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_sp <= in_item;
			px_sp   <= px_nxt;
			py_sp   <= py_nxt;
		end
	end

	assign out_v    = v_sp;
	assign out_item = item_sp;
	assign out_px   = px_sp;
	assign out_py   = py_sp;

endmodule

// ----- hdl/bpw_term.sv -----
// ----------------------------------------------------------------------------
// bpw_term
// Monomial stage, coefficient table and coefficient * monomial products.
// ----------------------------------------------------------------------------
module bpw_term #(
	parameter int MAX_ORDER   = bpw_pkg::DEF_MAX_ORDER,
	parameter int TABLE_DEPTH = bpw_pkg::DEF_TABLE_DEPTH,
	localparam int N1    = MAX_ORDER + 1,
	localparam int NT    = N1 * N1,
	localparam int ORD_W = $clog2(N1)
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     adv,
	input  logic [ORD_W-1:0]                         n,
	input  logic                                     in_v,
	input  bpw_pkg::item_t                           in_item,
	input  logic [MAX_ORDER:0][bpw_pkg::COORD_W-1:0] in_px,
	input  logic [MAX_ORDER:0][bpw_pkg::COORD_W-1:0] in_py,
	output logic                                     out_v,
	output logic [NT-1:0][bpw_pkg::PROD_W-1:0]       prodx,
	output logic [NT-1:0][bpw_pkg::PROD_W-1:0]       prody
);
	import bpw_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);

	logic                          v_sm;
	item_t                         item_sm;
	logic [NT-1:0][COORD_W-1:0]    mono_sm;
	logic [NT-1:0][COORD_W-1:0]    mono_nxt;

	logic [TABLE_DEPTH-1:0][COEFF_W-1:0] tbl_q;
	logic [NT-1:0][COEFF_W-1:0]          cx, cy;
	logic                                wr_en;
	logic [IDX_W-1:0]                    wr_idx;

	logic                       v_sc;
	logic [NT-1:0][PROD_W-1:0]  px_sc, py_sc;

	always_comb begin
		for (int i = 0; i < N1; i++) begin
			for (int j = 0; j < N1; j++) begin
				if (i == 0)
					mono_nxt[i*N1+j] = in_py[j];
				else if (j == 0)
					mono_nxt[i*N1+j] = in_px[i];
				else
					mono_nxt[i*N1+j] = q15_mul($signed(in_px[i]), $signed(in_py[j]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sm <= 1'b0;
			v_sc <= 1'b0;
		end else if (adv) begin
			v_sm <= in_v;
			v_sc <= v_sm && (item_sm.kind == KIND_POINT);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_sm <= in_item;
			mono_sm <= mono_nxt;
		end
	end

	// loads write here, in order with the points around them
	assign wr_en  = adv && v_sm && (item_sm.kind == KIND_LOAD)
	                && (int'(item_sm.coeff_index) < TABLE_DEPTH);
	assign wr_idx = IDX_W'(item_sm.coeff_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_q <= '0;
		end else if (wr_en) begin
			tbl_q[wr_idx] <= item_sm.coeff_value;
		end
	end

	// slot mapping follows the order in use; unused terms read zero
	always_comb begin
		int nn, off, sx, sy;
		nn  = int'(n);
		off = (nn + 1) * (nn + 1);
		for (int i = 0; i < N1; i++) begin
			for (int j = 0; j < N1; j++) begin
				sx = i * (nn + 1) + j;
				sy = off + sx;
				cx[i*N1+j] = '0;
				cy[i*N1+j] = '0;
				if (i <= nn && j <= nn) begin
					if (sx < TABLE_DEPTH)
						cx[i*N1+j] = tbl_q[IDX_W'(sx)];
					if (sy < TABLE_DEPTH)
						cy[i*N1+j] = tbl_q[IDX_W'(sy)];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int t = 0; t < NT; t++) begin
				px_sc[t] <= $signed(cx[t]) * $signed(mono_sm[t]);
				py_sc[t] <= $signed(cy[t]) * $signed(mono_sm[t]);
			end
		end
	end

	assign out_v = v_sc;
	assign prodx = px_sc;
	assign prody = py_sc;

endmodule

// ----- hdl/bpw_acc.sv -----
// ----------------------------------------------------------------------------
// bpw_acc
// Row sums, final sum, round half up to Q16.16, saturate; output register.
// ----------------------------------------------------------------------------
module bpw_acc #(
	parameter int MAX_ORDER = bpw_pkg::DEF_MAX_ORDER,
	localparam int N1 = MAX_ORDER + 1,
	localparam int NT = N1 * N1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  logic                                in_v,
	input  logic [NT-1:0][bpw_pkg::PROD_W-1:0]  prodx,
	input  logic [NT-1:0][bpw_pkg::PROD_W-1:0]  prody,
	output logic                                out_v,
	output logic [bpw_pkg::COEFF_W-1:0]         x_out,
	output logic [bpw_pkg::COEFF_W-1:0]         y_out,
	output logic                                clipped
);
	import bpw_pkg::*;

	localparam int ACC_W = PROD_W + $clog2(NT) + 1;
	localparam int SH_W  = ACC_W - 15;

	logic                        v_sr;
	logic [N1-1:0][ACC_W-1:0]    rx_sr, ry_sr;
	logic [N1-1:0][ACC_W-1:0]    rx_nxt, ry_nxt;
	logic signed [ACC_W-1:0]     tx, ty;
	logic [COEFF_W-1:0]          sx, sy;
	logic                        cx, cy;

	logic                        v_q;
	logic [COEFF_W-1:0]          x_q, y_q;
	logic                        clip_q;

	always_comb begin
		for (int i = 0; i < N1; i++) begin
			rx_nxt[i] = '0;
			ry_nxt[i] = '0;
			for (int j = 0; j < N1; j++) begin
				rx_nxt[i] = rx_nxt[i] + ACC_W'($signed(prodx[i*N1+j]));
				ry_nxt[i] = ry_nxt[i] + ACC_W'($signed(prody[i*N1+j]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sr <= 1'b0;
		end else if (adv) begin
			v_sr <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rx_sr <= rx_nxt;
			ry_sr <= ry_nxt;
		end
	end

	function automatic logic [COEFF_W:0] round_sat(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] r;
		logic [SH_W-1:0]         sh;
		r  = acc + ACC_W'(16384);
		sh = r[ACC_W-1:15];
		if (&sh[SH_W-1:COEFF_W-1] || ~|sh[SH_W-1:COEFF_W-1])
			return {1'b0, sh[COEFF_W-1:0]};
		else if (sh[SH_W-1])
			return {1'b1, 1'b1, {(COEFF_W-1){1'b0}}};
		return {1'b1, 1'b0, {(COEFF_W-1){1'b1}}};
	endfunction

	always_comb begin
		tx = '0;
		ty = '0;
		for (int i = 0; i < N1; i++) begin
			tx = tx + $signed(rx_sr[i]);
			ty = ty + $signed(ry_sr[i]);
		end
		{cx, sx} = round_sat(tx);
		{cy, sy} = round_sat(ty);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (adv) begin
			v_q <= v_sr;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_q    <= sx;
			y_q    <= sy;
			clip_q <= cx | cy;
		end
	end

	assign out_v   = v_q;
	assign x_out   = x_q;
	assign y_out   = y_q;
	assign clipped = clip_q;

endmodule
